### hw/rtl/iff_pkg.sv
`timescale 1ns / 1ps
package iff_pkg;

   localparam int VALUE_W         = 64;
   localparam int MAX_FIELD_WIDTH = 64;
   localparam int MAX_PRECISION   = 60;
   localparam int DIGIT_SLOTS     = 22;   // enough for 64 bits in octal
   localparam int DIGIT_W         = 4;
   localparam int OCT_W           = 3;
   localparam int WIDTH_W         = 7;
   localparam int PREC_W          = 6;
   localparam int CHAR_W          = 8;
   localparam int SLOT_CNT_W      = 5;
   localparam int BIT_CNT_W       = 6;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X_UP      = 8'h58;
   localparam logic [CHAR_W-1:0] CH_X_LOW     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_ALPHA_UP  = 8'h37;   // 'A' - 10
   localparam logic [CHAR_W-1:0] CH_ALPHA_LOW = 8'h57;   // 'a' - 10

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] base;
      if (d < 4'd10) begin
         base = CH_ZERO;
      end else begin
         base = upper ? CH_ALPHA_UP : CH_ALPHA_LOW;
      end
      return base + {{(CHAR_W-DIGIT_W){1'b0}}, d};
   endfunction

endpackage

### hw/rtl/integer_field_formatter.sv
`timescale 1ns / 1ps
// Sequence: decimal items run the double-dabble conversion (one bit per cycle), then one
//   alignment step per leading zero digit plus one, the count and plan states, and one character
//   per cycle while rsp_stall does not hold the output. Octal and hex skip the conversion loop.
// Flow: one item at a time; the next transfer is taken once the last character sits
//   in the output register.
// Reset: synchronous, active high; returns to idle and drops rsp_valid.
module integer_field_formatter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [iff_pkg::VALUE_W-1:0]        req_value,
   input  logic                               req_is_signed,
   input  logic [1:0]                         req_radix_sel,
   input  logic                               req_upper_case,
   input  logic [iff_pkg::WIDTH_W-1:0]        req_field_width,
   input  logic [iff_pkg::PREC_W-1:0]         req_precision,
   input  logic                               req_precision_given,
   input  logic                               req_show_base,
   input  logic                               req_zero_fill,
   input  logic                               req_left_justify,
   input  logic                               req_force_plus,
   input  logic                               req_space_sign,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [iff_pkg::CHAR_W-1:0]         rsp_char_out,
   output logic                               rsp_last
);

   localparam int DW       = iff_pkg::DIGIT_W;
   localparam int DIG_BITS = iff_pkg::DIGIT_SLOTS * DW;
   localparam int VW       = iff_pkg::VALUE_W;
   localparam int WW       = iff_pkg::WIDTH_W;
   localparam int PW       = iff_pkg::PREC_W;
   localparam int CW       = iff_pkg::CHAR_W;
   localparam int SW       = iff_pkg::SLOT_CNT_W;
   localparam int BW       = iff_pkg::BIT_CNT_W;
   localparam int OCT_SRC  = iff_pkg::DIGIT_SLOTS * iff_pkg::OCT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,     // binary to BCD, one bit per cycle
      ST_ALIGN,    // shift the leading digit to the top slot
      ST_COUNT,
      ST_PLAN,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [VW-1:0]         bin_ff;
   logic [DIG_BITS-1:0]   dig_ff;
   logic [BW-1:0]         cnt_ff;
   logic [SW-1:0]         sh_ff;

   // captured options
   logic [CW-1:0]         sign_ch_ff;
   logic                  has_sign_ff;
   logic                  is_oct_ff;
   logic                  is_hex_ff;
   logic                  upper_ff;
   logic [WW-1:0]         width_ff;
   logic [PW-1:0]         prec_ff;
   logic                  prec_given_ff;
   logic                  alt_ff;
   logic                  zpad_ff;
   logic                  left_ff;
   logic                  mag_zero_ff;

   // field plan
   logic [SW-1:0]         ndig_ff;
   logic [PW-1:0]         zeros_ff;
   logic                  prefix_ff;
   logic [WW-1:0]         len_ff;
   logic [WW-1:0]         b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, tot_ff;
   logic [WW-1:0]         pos_ff;

   logic                  rsp_valid_ff;
   logic [CW-1:0]         rsp_char_ff;
   logic                  rsp_last_ff;

   // ---------------------------------------------------------------------------------------
   // Intake: magnitude, sign character, radix decode, saturation
   // ---------------------------------------------------------------------------------------
   logic                  accept;
   logic [VW-1:0]         mag_in;
   logic                  neg_in;
   logic [CW-1:0]         sign_ch_in;
   logic                  has_sign_in;
   logic                  is_oct_in;
   logic                  is_hex_in;
   logic [WW-1:0]         width_in;
   logic [PW-1:0]         prec_in;
   logic [OCT_SRC-1:0]    oct_src;
   logic [DIG_BITS-1:0]   oct_load;
   logic [DIG_BITS-1:0]   hex_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign neg_in = req_is_signed && req_value[VW-1];
   assign mag_in = neg_in ? ({VW{1'b0}} - req_value) : req_value;

   always_comb begin
      has_sign_in = 1'b0;
      sign_ch_in  = iff_pkg::CH_SPACE;
      if (neg_in) begin
         has_sign_in = 1'b1;
         sign_ch_in  = iff_pkg::CH_MINUS;
      end else if (req_is_signed && req_force_plus) begin
         has_sign_in = 1'b1;
         sign_ch_in  = iff_pkg::CH_PLUS;
      end else if (req_is_signed && req_space_sign) begin
         has_sign_in = 1'b1;
         sign_ch_in  = iff_pkg::CH_SPACE;
      end
   end

   always_comb begin
      is_oct_in = 1'b0;
      is_hex_in = 1'b0;
      unique case (iff_pkg::radix_type'(req_radix_sel))
         iff_pkg::RADIX_OCT: begin
            is_oct_in = 1'b1;
         end
         iff_pkg::RADIX_HEX: begin
            is_hex_in = 1'b1;
         end
         default: begin
            // decimal, and the unused code
         end
      endcase
   end

   assign width_in = (req_field_width > WW'(iff_pkg::MAX_FIELD_WIDTH))
                   ? WW'(iff_pkg::MAX_FIELD_WIDTH) : req_field_width;
   assign prec_in  = (req_precision > PW'(iff_pkg::MAX_PRECISION))
                   ? PW'(iff_pkg::MAX_PRECISION) : req_precision;

   // octal and hex digits are plain bit groups of the magnitude
   assign oct_src  = {{(OCT_SRC-VW){1'b0}}, mag_in};
   assign hex_load = {{(DIG_BITS-VW){1'b0}}, mag_in};

   always_comb begin
      for (int i = 0; i < iff_pkg::DIGIT_SLOTS; i++) begin
         oct_load[i*DW +: DW] = {1'b0, oct_src[i*iff_pkg::OCT_W +: iff_pkg::OCT_W]};
      end
   end

   // ---------------------------------------------------------------------------------------
   // Double dabble: add 3 to every BCD digit of 5 or more, then shift one bit in
   // ---------------------------------------------------------------------------------------
   logic [DIG_BITS-1:0]   dabble_adj;
   logic [DIG_BITS-1:0]   dabble_in;

   always_comb begin
      for (int i = 0; i < iff_pkg::DIGIT_SLOTS; i++) begin
         dabble_adj[i*DW +: DW] = (dig_ff[i*DW +: DW] >= 4'd5)
                                ? dig_ff[i*DW +: DW] + 4'd3 : dig_ff[i*DW +: DW];
      end
   end

   assign dabble_in = {dabble_adj[DIG_BITS-2:0], bin_ff[VW-1]};

   // ---------------------------------------------------------------------------------------
   // Alignment: the leading digit ends up in the top slot; sh_ff counts leading zero digits
   // ---------------------------------------------------------------------------------------
   logic [DW-1:0]         top_digit;
   logic                  align_step;

   assign top_digit  = dig_ff[DIG_BITS-1 -: DW];
   assign align_step = (top_digit == {DW{1'b0}}) && (sh_ff < SW'(iff_pkg::DIGIT_SLOTS - 1));

   // ---------------------------------------------------------------------------------------
   // Field counts
   // ---------------------------------------------------------------------------------------
   logic                  no_digits;
   logic [SW-1:0]         ndig_in;
   logic [PW-1:0]         zeros_in;
   logic                  prefix_in;
   logic [WW-1:0]         len_in;

   // explicit zero precision on a zero value prints no digits at all
   assign no_digits = mag_zero_ff && prec_given_ff && (prec_ff == {PW{1'b0}});
   assign ndig_in   = no_digits ? {SW{1'b0}} : (SW'(iff_pkg::DIGIT_SLOTS) - sh_ff);

   always_comb begin
      if (prec_given_ff && (prec_ff > PW'(ndig_in))) begin
         zeros_in = prec_ff - PW'(ndig_in);
      end else begin
         zeros_in = {PW{1'b0}};
      end
      // octal alternate form: the first digit must be a zero
      if (is_oct_ff && alt_ff && (zeros_in == {PW{1'b0}})
          && ((ndig_in == {SW{1'b0}}) || !mag_zero_ff)) begin
         zeros_in = PW'(1);
      end
   end

   assign prefix_in = is_hex_ff && alt_ff && !mag_zero_ff;
   assign len_in    = WW'(has_sign_ff) + (prefix_in ? WW'(2) : {WW{1'b0}})
                    + WW'(zeros_in) + WW'(ndig_in);

   // ---------------------------------------------------------------------------------------
   // Segment boundaries: lead spaces | sign | 0x | zero fill + precision zeros | digits | trail
   // ---------------------------------------------------------------------------------------
   logic [WW-1:0]         pad;
   logic                  zfill_mode;
   logic [WW-1:0]         lead_cnt, zfill_cnt, trail_cnt;
   logic [WW-1:0]         b1_in, b2_in, b3_in, b4_in, b5_in, tot_in;

   assign pad        = (width_ff > len_ff) ? (width_ff - len_ff) : {WW{1'b0}};
   assign zfill_mode = zpad_ff && !left_ff && !prec_given_ff;
   assign lead_cnt   = (!left_ff && !zfill_mode) ? pad : {WW{1'b0}};
   assign zfill_cnt  = zfill_mode ? pad : {WW{1'b0}};
   assign trail_cnt  = left_ff ? pad : {WW{1'b0}};

   assign b1_in  = lead_cnt;
   assign b2_in  = b1_in + WW'(has_sign_ff);
   assign b3_in  = b2_in + (prefix_ff ? WW'(2) : {WW{1'b0}});
   assign b4_in  = b3_in + zfill_cnt + WW'(zeros_ff);
   assign b5_in  = b4_in + WW'(ndig_ff);
   assign tot_in = b5_in + trail_cnt;

   // ---------------------------------------------------------------------------------------
   // Character emitter
   // ---------------------------------------------------------------------------------------
   logic                  emit_go;
   logic                  in_digits;
   logic                  is_last;
   logic [CW-1:0]         char_in;

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign in_digits = (pos_ff >= b4_ff) && (pos_ff < b5_ff);
   assign is_last   = ((pos_ff + WW'(1)) == tot_ff);

   always_comb begin
      if (pos_ff < b1_ff) begin
         char_in = iff_pkg::CH_SPACE;
      end else if (pos_ff < b2_ff) begin
         char_in = sign_ch_ff;
      end else if (pos_ff < b3_ff) begin
         if (pos_ff == b2_ff) begin
            char_in = iff_pkg::CH_ZERO;
         end else begin
            char_in = upper_ff ? iff_pkg::CH_X_UP : iff_pkg::CH_X_LOW;
         end
      end else if (pos_ff < b4_ff) begin
         char_in = iff_pkg::CH_ZERO;
      end else if (in_digits) begin
         char_in = iff_pkg::digit_char(top_digit, upper_ff);
      end else begin
         char_in = iff_pkg::CH_SPACE;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register drains unless a new character replaces it this cycle
         if (rsp_valid_ff && !rsp_stall && !emit_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sign_ch_ff    <= sign_ch_in;
                  has_sign_ff   <= has_sign_in;
                  is_oct_ff     <= is_oct_in;
                  is_hex_ff     <= is_hex_in;
                  upper_ff      <= req_upper_case;
                  width_ff      <= width_in;
                  prec_ff       <= prec_in;
                  prec_given_ff <= req_precision_given;
                  alt_ff        <= req_show_base;
                  zpad_ff       <= req_zero_fill;
                  left_ff       <= req_left_justify;
                  mag_zero_ff   <= (mag_in == {VW{1'b0}});
                  bin_ff        <= mag_in;
                  cnt_ff        <= {BW{1'b0}};
                  sh_ff         <= {SW{1'b0}};
                  if (is_oct_in) begin
                     dig_ff   <= oct_load;
                     state_ff <= ST_ALIGN;
                  end else if (is_hex_in) begin
                     dig_ff   <= hex_load;
                     state_ff <= ST_ALIGN;
                  end else begin
                     dig_ff   <= {DIG_BITS{1'b0}};
                     state_ff <= ST_CONV;
                  end
               end
            end
            ST_CONV: begin
               dig_ff <= dabble_in;
               bin_ff <= {bin_ff[VW-2:0], 1'b0};
               cnt_ff <= cnt_ff + BW'(1);
               if (cnt_ff == BW'(VW - 1)) begin
                  state_ff <= ST_ALIGN;
               end
            end
            ST_ALIGN: begin
               if (align_step) begin
                  dig_ff <= {dig_ff[DIG_BITS-DW-1:0], {DW{1'b0}}};
                  sh_ff  <= sh_ff + SW'(1);
               end else begin
                  state_ff <= ST_COUNT;
               end
            end
            ST_COUNT: begin
               ndig_ff   <= ndig_in;
               zeros_ff  <= zeros_in;
               prefix_ff <= prefix_in;
               len_ff    <= len_in;
               state_ff  <= ST_PLAN;
            end
            ST_PLAN: begin
               b1_ff  <= b1_in;
               b2_ff  <= b2_in;
               b3_ff  <= b3_in;
               b4_ff  <= b4_in;
               b5_ff  <= b5_in;
               tot_ff <= tot_in;
               pos_ff <= {WW{1'b0}};
               // an empty field produces no transfer at all
               state_ff <= (tot_in == {WW{1'b0}}) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_char_ff  <= char_in;
                  rsp_last_ff  <= is_last;
                  if (in_digits) begin
                     dig_ff <= {dig_ff[DIG_BITS-DW-1:0], {DW{1'b0}}};
                  end
                  if (is_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pos_ff <= pos_ff + WW'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### hw/rtl/iff_checker.sv
`timescale 1ns / 1ps
module iff_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [iff_pkg::CHAR_W-1:0]         rsp_char_out,
   input logic                               rsp_last
);

   // a stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_char_out) && $stable(rsp_last)))
      else $error("stalled character changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a field is in flight");

   // no new field may start until the current one has emitted its last character
   a_busy_midfield: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("input open in the middle of a field");

   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_char_out >= iff_pkg::CH_SPACE) && (rsp_char_out <= iff_pkg::CH_X_LOW)))
      else $error("character outside the formatter alphabet");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (.*);
